// ===== rtl/core/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants for the byte deque engine: opcodes, result
// status codes and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REVERSE    = 3'd4,
      OP_REMOVE     = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      RS_OK    = 2'd0,
      RS_EMPTY = 2'd1,
      RS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       do_push;
      logic       do_pop;
      logic       end_front;
      logic       do_rev;
      logic       rm_start;
      logic       rm_step;
      logic       rm_commit;
      logic       rsp_load;
      logic       rsp_pop;
      logic       rsp_removed;
      status_type rsp_status;
   } bde_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic scan_done;
      logic rsp_hold;
   } bde_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/bde_ram.sv =====
// ----------------------------------------------------------------------------
// bde_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bde_ctrl.sv =====
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller for the byte deque engine: decodes each word and sequences
// pops and the remove scan through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_opcode,
   input  wire bde_pkg::bde_stat_type stat,
   output bde_pkg::bde_cmd_type       cmd
);

   import bde_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_POP    = 3'b010,
      ST_REMOVE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || stat.rsp_hold;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = RS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     cmd.rsp_load  = 1'b1;
                     cmd.end_front = (req_opcode == OP_PUSH_FRONT);
                     if (stat.full) begin
                        cmd.rsp_status = RS_FULL;
                     end else begin
                        cmd.do_push = 1'b1;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     cmd.end_front = (req_opcode == OP_POP_FRONT);
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = RS_EMPTY;
                     end else begin
                        cmd.do_pop = 1'b1;
                        state_in   = ST_POP;
                     end
                  end
                  OP_REVERSE: begin
                     cmd.do_rev   = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  OP_REMOVE: begin
                     if (stat.empty) begin
                        cmd.rsp_load = 1'b1;
                     end else begin
                        cmd.rm_start = 1'b1;
                        state_in     = ST_REMOVE;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_pop  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_REMOVE: begin
            cmd.rm_step = 1'b1;
            if (stat.scan_done) begin
               cmd.rm_commit   = 1'b1;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_removed = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bde_dp.sv =====
// ----------------------------------------------------------------------------
// bde_dp
// Datapath for the byte deque engine: ring pointers, two store banks used in
// turn for compaction, the remove scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_dp #(
   parameter int unsigned DEPTH = bde_pkg::DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bde_pkg::bde_cmd_type         cmd,
   output bde_pkg::bde_stat_type             stat,
   input  wire logic [7:0]                   req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [7:0]                   rsp_out_value,
   output logic                              rsp_out_valid,
   output logic      [1:0]                   rsp_status,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_removed_count
);

   import bde_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic          bank_ff, bank_in;
   logic [AW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] removed_ff, removed_in;
   logic [7:0]    match_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_value_ff;
   logic          rsp_flag_ff;
   status_type    rsp_status_ff;
   logic [CW-1:0] rsp_occ_ff;
   logic [CW-1:0] rsp_removed_ff;

   logic [AW-1:0] front_inc, front_dec, scan_inc, scan_dec;
   logic [CW:0]   sum_end, sum_last;
   logic [AW-1:0] tail_put, tail_last;
   logic          low;
   logic          scan_live;
   logic          keep_wr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data, rd_data0, rd_data1;
   logic [AW-1:0] push_addr;
   logic          wr_en0, wr_en1;
   logic [AW-1:0] wr_addr0, wr_addr1;
   logic [7:0]    wr_data0, wr_data1;

   // ring pointer arithmetic
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign scan_inc  = (scan_ptr_ff == LAST_SLOT) ? '0 : scan_ptr_ff + 1'b1;
   assign scan_dec  = (scan_ptr_ff == '0) ? LAST_SLOT : scan_ptr_ff - 1'b1;

   assign sum_end   = {1'b0, CW'(front_ff)} + {1'b0, count_ff};
   assign sum_last  = sum_end - 1'b1;
   assign tail_put  = (sum_end >= DEPTH_X) ? AW'(sum_end - DEPTH_X) : AW'(sum_end);
   assign tail_last = (sum_last >= DEPTH_X) ? AW'(sum_last - DEPTH_X) : AW'(sum_last);

   assign low       = cmd.end_front ^ rev_ff;
   assign scan_live = cmd.rm_step && (idx_ff != count_ff);
   assign keep_wr   = cmd.rm_step && pend_ff && (rd_data != match_ff);

   // store access
   assign rd_en     = cmd.do_pop || scan_live;
   assign rd_addr   = cmd.do_pop ? (low ? front_ff : tail_last) : scan_ptr_ff;
   assign rd_data   = bank_ff ? rd_data1 : rd_data0;
   assign push_addr = low ? front_dec : tail_put;

   always_comb begin
      wr_en0   = (cmd.do_push && !bank_ff) || (keep_wr && bank_ff);
      wr_en1   = (cmd.do_push && bank_ff) || (keep_wr && !bank_ff);
      wr_addr0 = bank_ff ? keep_ff[AW-1:0] : push_addr;
      wr_addr1 = bank_ff ? push_addr : keep_ff[AW-1:0];
      wr_data0 = bank_ff ? rd_data : req_value;
      wr_data1 = bank_ff ? req_value : rd_data;
   end

   bde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (wr_addr0),
      .wr_data (wr_data0),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   bde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (wr_addr1),
      .wr_data (wr_data1),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // queue state
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      rev_in      = rev_ff;
      bank_in     = bank_ff;
      scan_ptr_in = scan_ptr_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      keep_in     = keep_ff;
      removed_in  = removed_ff;
      if (cmd.do_push) begin
         count_in = count_ff + 1'b1;
         if (low) begin
            front_in = front_dec;
         end
      end
      if (cmd.do_pop) begin
         count_in = count_ff - 1'b1;
         if (low) begin
            front_in = front_inc;
         end
      end
      if (cmd.do_rev) begin
         rev_in = !rev_ff;
      end
      if (cmd.rm_start) begin
         scan_ptr_in = rev_ff ? tail_last : front_ff;
         idx_in      = '0;
         keep_in     = '0;
         removed_in  = '0;
      end
      if (scan_live) begin
         scan_ptr_in = rev_ff ? scan_dec : scan_inc;
         idx_in      = idx_ff + 1'b1;
         pend_in     = 1'b1;
      end
      if (cmd.rm_step && pend_ff) begin
         if (rd_data == match_ff) begin
            removed_in = removed_ff + 1'b1;
         end else begin
            keep_in = keep_ff + 1'b1;
         end
      end
      if (cmd.rm_commit) begin
         count_in = keep_ff;
         front_in = '0;
         rev_in   = 1'b0;
         bank_in  = !bank_ff;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         bank_ff      <= bank_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      keep_ff     <= keep_in;
      removed_ff  <= removed_in;
      if (cmd.rm_start) begin
         match_ff <= req_value;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff   <= cmd.rsp_pop ? rd_data : 8'd0;
         rsp_flag_ff    <= cmd.rsp_pop;
         rsp_status_ff  <= cmd.rsp_status;
         rsp_occ_ff     <= count_in;
         rsp_removed_ff <= cmd.rsp_removed ? removed_ff : '0;
      end
   end

   assign stat.full      = (count_ff == DEPTH_C);
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = (idx_ff == count_ff) && !pend_ff;
   assign stat.rsp_hold  = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_valid     = rsp_flag_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_removed_count = rsp_removed_ff;

endmodule

`default_nettype wire

// ===== rtl/core/byte_deque_engine.sv =====
// ----------------------------------------------------------------------------
// byte_deque_engine
// Double-ended queue of bytes held in a ring store of DEPTH entries.
//
// Usage:
//   req_* carries one word per item: opcode and value. rsp_* returns one word
//   per item: popped byte and its flag, status, occupancy and removed count.
//   Both channels take a word on a clock edge where valid is high and stall
//   is low.
//   Push, reverse, unused opcodes, failed pops/pushes and removes on an
//   empty queue: result registered at acceptance, one item per cycle
//   sustained while the result is not stalled. Pop: result loaded in the pop
//   state from the registered read of the store RAM. Remove matching: one
//   entry per cycle through the store read port; survivors are written in
//   order into the other of two RAM banks, which then becomes the live store.
//   After reset the queue is empty and can take an item at once; no RAM
//   clearing pass is run.
//   A stalled result holds in the output register and req_stall stays high
//   until it is taken; an item is also held off while a pop or remove runs.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_deque_engine #(
   parameter int unsigned DEPTH = bde_pkg::DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_opcode,
   input  wire logic [7:0]                   req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [7:0]                   rsp_out_value,
   output logic                              rsp_out_valid,
   output logic      [1:0]                   rsp_status,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_removed_count
);

   import bde_pkg::*;

   bde_cmd_type  cmd;
   bde_stat_type stat;

   bde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   bde_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

`default_nettype wire
